>>> src/text_to_page_command_encoder_core_macros.svh
// ----------------------------------------------------------------------------
// Text to page-command encoder: assertion macros
// Shorthand for the clocked, reset-qualified properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_TO_PAGE_COMMAND_ENCODER_CORE_MACROS_SVH
`define TEXT_TO_PAGE_COMMAND_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define TTP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ttp checker: property violated");

// Next-cycle implication, checked on every rising edge outside reset
`define TTP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ttp checker: property violated");

`endif

>>> src/ttp_pkg.sv
// ----------------------------------------------------------------------------
// ttp_pkg
// Types, codes and string tables shared by the text to page-command encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ttp_pkg;

  // Field and register widths
  localparam int OpW     = 2;
  localparam int ByteW   = 8;
  localparam int TabW    = 6;
  localparam int ColW    = 16;
  localparam int LineW   = 16;
  localparam int AddrW   = 4;
  localparam int DataW   = 32;
  localparam int MAX_TAB = 32;
  localparam int RemW    = $clog2(MAX_TAB);
  localparam int IdxW    = $clog2(MAX_TAB);

  // Opcodes of an input request
  localparam logic [OpW-1:0] OP_DATA  = 2'd0;
  localparam logic [OpW-1:0] OP_START = 2'd1;
  localparam logic [OpW-1:0] OP_END   = 2'd2;
  localparam logic [OpW-1:0] OP_NONE  = 2'd3;

  // Register indexes (word address bits)
  localparam logic [1:0] REG_TAB_WIDTH  = 2'd0;
  localparam logic [1:0] REG_LINE_WIDTH = 2'd1;
  localparam logic [1:0] REG_PAGE_LINES = 2'd2;

  // Register reset values
  localparam logic [TabW-1:0]  TAB_WIDTH_RST  = 6'd8;
  localparam logic [ColW-1:0]  LINE_WIDTH_RST = 16'd10000;
  localparam logic [LineW-1:0] PAGE_LINES_RST = 16'd10000;
  localparam logic [LineW-1:0] LINE_ONE       = 16'd1;

  // Character codes
  localparam logic [ByteW-1:0] CH_TAB    = 8'h09;
  localparam logic [ByteW-1:0] CH_NL     = 8'h0A;
  localparam logic [ByteW-1:0] CH_FF     = 8'h0C;
  localparam logic [ByteW-1:0] CH_CR     = 8'h0D;
  localparam logic [ByteW-1:0] CH_SPACE  = 8'h20;
  localparam logic [ByteW-1:0] CH_LPAREN = 8'h28;
  localparam logic [ByteW-1:0] CH_RPAREN = 8'h29;
  localparam logic [ByteW-1:0] CH_ZERO   = 8'h30;
  localparam logic [ByteW-1:0] CH_QMARK  = 8'h3F;
  localparam logic [ByteW-1:0] CH_BSLASH = 8'h5C;
  localparam logic [ByteW-1:0] CH_LOW_N  = 8'h6E;
  localparam logic [ByteW-1:0] CH_LOW_P  = 8'h70;
  localparam logic [ByteW-1:0] CH_LOW_R  = 8'h72;
  localparam logic [ByteW-1:0] CH_TILDE  = 8'h7E;

  // Output segments; also the controller states
  typedef enum logic [3:0] {
    SEG_IDLE,
    SEG_DIV,
    SEG_OPEN,
    SEG_EOF,
    SEG_NLHEAD,
    SEG_PAGE,
    SEG_NLOPEN,
    SEG_CR,
    SEG_FF,
    SEG_ESC,
    SEG_TAB
  } seg_e;

  // Class of an incoming request
  typedef enum logic [2:0] {
    KIND_DROP,
    KIND_OPEN,
    KIND_EOF,
    KIND_TAB,
    KIND_NL,
    KIND_CR,
    KIND_FF,
    KIND_CHAR
  } kind_e;

  typedef struct packed {
    logic [TabW-1:0]  tab_width;
    logic [ColW-1:0]  line_width_limit;
    logic [LineW-1:0] page_line_limit;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    seg_e seg;
    logic accept;
    logic div_start;
    logic emit;
    logic last;
    logic seg_end;
    logic col_clear;
    logic col_inc;
    logic col_tab;
    logic line_reset;
    logic line_adv;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    kind_e kind;
    logic  wrap;
    logic  page;
    logic  seg_last;
    logic  out_free;
    logic  div_busy;
  } sts_t;

  // Index of the final byte of a fixed string segment
  function automatic logic [2:0] str_last(seg_e seg);
    logic [2:0] r;
    unique case (seg)
      SEG_EOF:    r = 3'd6;
      SEG_NLHEAD: r = 3'd3;
      SEG_PAGE:   r = 3'd1;
      SEG_CR:     r = 3'd4;
      SEG_FF:     r = 3'd6;
      default:    r = 3'd0;
    endcase
    return r;
  endfunction

  // Byte of a fixed string segment at a given position
  function automatic logic [ByteW-1:0] str_byte(seg_e seg, logic [2:0] idx);
    logic [ByteW-1:0] b;
    b = CH_LPAREN;
    unique case (seg)
      SEG_EOF: begin
        case (idx)
          3'd0:    b = CH_RPAREN;
          3'd1:    b = CH_SPACE;
          3'd2:    b = CH_LOW_N;
          3'd3:    b = CH_SPACE;
          3'd4:    b = CH_LOW_P;
          3'd5:    b = CH_NL;
          default: b = CH_FF;
        endcase
      end
      SEG_NLHEAD: begin
        case (idx)
          3'd0:    b = CH_RPAREN;
          3'd1:    b = CH_SPACE;
          3'd2:    b = CH_LOW_N;
          default: b = CH_NL;
        endcase
      end
      SEG_PAGE: begin
        b = (idx == 3'd0) ? CH_LOW_P : CH_NL;
      end
      SEG_CR: begin
        case (idx)
          3'd0:    b = CH_RPAREN;
          3'd1:    b = CH_SPACE;
          3'd2:    b = CH_LOW_R;
          3'd3:    b = CH_NL;
          default: b = CH_LPAREN;
        endcase
      end
      SEG_FF: begin
        case (idx)
          3'd0:    b = CH_RPAREN;
          3'd1:    b = CH_SPACE;
          3'd2:    b = CH_LOW_N;
          3'd3:    b = CH_SPACE;
          3'd4:    b = CH_LOW_P;
          3'd5:    b = CH_NL;
          default: b = CH_LPAREN;
        endcase
      end
      default: b = CH_LPAREN;
    endcase
    return b;
  endfunction

endpackage

>>> src/ttp_in_if.sv
// ----------------------------------------------------------------------------
// ttp_in_if
// Input request channel: opcode and text byte with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ttp_in_if;
  logic                       valid;
  logic                       ready;
  logic [ttp_pkg::OpW-1:0]    opcode;
  logic [ttp_pkg::ByteW-1:0]  in_byte;

  modport source (output valid, output opcode, output in_byte, input ready);
  modport sink   (input valid, input opcode, input in_byte, output ready);
endinterface

>>> src/ttp_out_if.sv
// ----------------------------------------------------------------------------
// ttp_out_if
// Output request channel: command byte and end-of-run flag with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ttp_out_if;
  logic                       valid;
  logic                       ready;
  logic [ttp_pkg::ByteW-1:0]  out_byte;
  logic                       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

>>> src/text_to_page_command_encoder_core.sv
// ----------------------------------------------------------------------------
// text_to_page_command_encoder_core
// Text byte stream to page-description command bytes, with APB configuration.
// ----------------------------------------------------------------------------
// An accepted request passes through the sequencer and then emits one command
// byte per cycle while the output channel is ready. A tab first waits on the
// bit-serial remainder unit, which takes one column bit per cycle, and then
// emits 1 to 32 spaces. The next request is taken once the last byte of the
// current one sits in the output register, even if it is not yet taken.
// There is no clearing pass after reset.
`timescale 1ns / 1ps

module text_to_page_command_encoder_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ttp_pkg::AddrW-1:0]   paddr,
  input  logic [ttp_pkg::DataW-1:0]   pwdata,
  output logic [ttp_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  ttp_in_if.sink                      in_chan,
  ttp_out_if.source                   out_chan
);

  ttp_pkg::cfg_t cfg;
  ttp_pkg::cmd_t cmd;
  ttp_pkg::sts_t sts;
  logic          in_ready;

  ttp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ttp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ttp_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_i       (cfg),
    .in_opcode_i (in_chan.opcode),
    .in_byte_i   (in_chan.in_byte),
    .out_ready_i (out_chan.ready),
    .out_valid_o (out_chan.valid),
    .out_byte_o  (out_chan.out_byte),
    .out_last_o  (out_chan.last_of_run)
  );

  assign in_chan.ready = in_ready;

endmodule

>>> src/ttp_regs.sv
// ----------------------------------------------------------------------------
// ttp_regs
// APB configuration registers: tab width, line width limit, page line limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttp_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ttp_pkg::AddrW-1:0]   paddr,
  input  logic [ttp_pkg::DataW-1:0]   pwdata,
  output logic [ttp_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output ttp_pkg::cfg_t               cfg_o
);

  ttp_pkg::cfg_t cfg_q;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  // Write the addressed register in the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tab_width        <= ttp_pkg::TAB_WIDTH_RST;
      cfg_q.line_width_limit <= ttp_pkg::LINE_WIDTH_RST;
      cfg_q.page_line_limit  <= ttp_pkg::PAGE_LINES_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        ttp_pkg::REG_TAB_WIDTH:  cfg_q.tab_width        <= pwdata[ttp_pkg::TabW-1:0];
        ttp_pkg::REG_LINE_WIDTH: cfg_q.line_width_limit <= pwdata[ttp_pkg::ColW-1:0];
        ttp_pkg::REG_PAGE_LINES: cfg_q.page_line_limit  <= pwdata[ttp_pkg::LineW-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (paddr[3:2])
      ttp_pkg::REG_TAB_WIDTH:
        prdata = {{(ttp_pkg::DataW-ttp_pkg::TabW){1'b0}}, cfg_q.tab_width};
      ttp_pkg::REG_LINE_WIDTH:
        prdata = {{(ttp_pkg::DataW-ttp_pkg::ColW){1'b0}}, cfg_q.line_width_limit};
      ttp_pkg::REG_PAGE_LINES:
        prdata = {{(ttp_pkg::DataW-ttp_pkg::LineW){1'b0}}, cfg_q.page_line_limit};
      default:
        prdata = '0;
    endcase
  end

endmodule

>>> src/ttp_rem.sv
// ----------------------------------------------------------------------------
// ttp_rem
// Bit-serial remainder of the column by the tab width, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttp_rem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ttp_pkg::ColW-1:0]    dividend_i,
  input  logic [ttp_pkg::TabW-1:0]    divisor_i,
  output logic                        busy_o,
  output logic [ttp_pkg::RemW-1:0]    rem_o
);

  localparam int CntW = $clog2(ttp_pkg::ColW);

  logic                      busy_q;
  logic [CntW-1:0]           cnt_q;
  logic [ttp_pkg::ColW-1:0]  sh_q;
  logic [ttp_pkg::RemW-1:0]  rem_q;
  logic [ttp_pkg::RemW:0]    trial;
  logic [ttp_pkg::RemW:0]    rem_d;

  // Shift in the next dividend bit and subtract the divisor when it fits
  always_comb begin
    trial = {rem_q, sh_q[ttp_pkg::ColW-1]};
    if (trial >= divisor_i) begin
      rem_d = trial - divisor_i;
    end else begin
      rem_d = trial;
    end
  end

  // Control: busy for one cycle per dividend bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(ttp_pkg::ColW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath: partial remainder and dividend shifter
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      sh_q  <= {sh_q[ttp_pkg::ColW-2:0], 1'b0};
      rem_q <= rem_d[ttp_pkg::RemW-1:0];
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

>>> src/ttp_datapath.sv
// ----------------------------------------------------------------------------
// ttp_datapath
// Column and line counters, request decode, byte selection and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttp_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ttp_pkg::cmd_t               cmd_i,
  output ttp_pkg::sts_t               sts_o,
  input  ttp_pkg::cfg_t               cfg_i,
  input  logic [ttp_pkg::OpW-1:0]     in_opcode_i,
  input  logic [ttp_pkg::ByteW-1:0]   in_byte_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [ttp_pkg::ByteW-1:0]   out_byte_o,
  output logic                        out_last_o
);

  logic [ttp_pkg::ColW-1:0]   column_q;
  logic [ttp_pkg::LineW-1:0]  line_q;
  logic [ttp_pkg::ByteW-1:0]  ch_q;
  logic [ttp_pkg::IdxW-1:0]   idx_q;
  logic                       out_valid_q;
  logic [ttp_pkg::ByteW-1:0]  out_byte_q;
  logic                       out_last_q;

  ttp_pkg::kind_e             kind;
  logic [ttp_pkg::ByteW-1:0]  map_ch;
  logic [ttp_pkg::TabW-1:0]   t_eff;
  logic [ttp_pkg::RemW-1:0]   rem;
  logic                       div_busy;
  logic [ttp_pkg::TabW-1:0]   n_spaces;
  logic [ttp_pkg::ColW:0]     tab_stop;
  logic [ttp_pkg::LineW:0]    line_next;
  logic                       page;
  logic                       is_oct;
  logic                       is_esc;
  logic                       esc_last;
  logic [ttp_pkg::ByteW-1:0]  esc_byte;
  logic                       seg_last;
  logic [ttp_pkg::ByteW-1:0]  byte_sel;

  // Classify the incoming request and map stray control bytes
  always_comb begin
    map_ch = in_byte_i;
    kind   = ttp_pkg::KIND_DROP;
    unique case (in_opcode_i)
      ttp_pkg::OP_START: kind = ttp_pkg::KIND_OPEN;
      ttp_pkg::OP_END:   kind = ttp_pkg::KIND_EOF;
      ttp_pkg::OP_DATA: begin
        unique case (in_byte_i)
          ttp_pkg::CH_TAB: kind = ttp_pkg::KIND_TAB;
          ttp_pkg::CH_NL:  kind = ttp_pkg::KIND_NL;
          ttp_pkg::CH_CR:  kind = ttp_pkg::KIND_CR;
          ttp_pkg::CH_FF:  kind = ttp_pkg::KIND_FF;
          default: begin
            kind = ttp_pkg::KIND_CHAR;
            if (in_byte_i < ttp_pkg::CH_SPACE) begin
              map_ch = ttp_pkg::CH_QMARK;
            end
          end
        endcase
      end
      default: kind = ttp_pkg::KIND_DROP;
    endcase
  end

  // Clamp the tab width into one to the maximum tab stop
  always_comb begin
    if (cfg_i.tab_width == '0) begin
      t_eff = ttp_pkg::TabW'(1);
    end else if (cfg_i.tab_width > ttp_pkg::TabW'(ttp_pkg::MAX_TAB)) begin
      t_eff = ttp_pkg::TabW'(ttp_pkg::MAX_TAB);
    end else begin
      t_eff = cfg_i.tab_width;
    end
  end

  ttp_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (column_q),
    .divisor_i  (t_eff),
    .busy_o     (div_busy),
    .rem_o      (rem)
  );

  // Tab stop and line advance arithmetic
  assign n_spaces  = t_eff - {1'b0, rem};
  assign tab_stop  = {1'b0, column_q} + {{(ttp_pkg::ColW+1-ttp_pkg::TabW){1'b0}}, n_spaces};
  assign line_next = {1'b0, line_q} + 1'b1;
  assign page      = line_next > {1'b0, cfg_i.page_line_limit};

  // Escaped character bytes
  assign is_oct = ch_q > ttp_pkg::CH_TILDE;
  assign is_esc = (ch_q == ttp_pkg::CH_LPAREN) || (ch_q == ttp_pkg::CH_RPAREN) ||
                  (ch_q == ttp_pkg::CH_BSLASH);

  always_comb begin
    esc_byte = ch_q;
    if (is_oct) begin
      esc_last = (idx_q == ttp_pkg::IdxW'(3));
      case (idx_q[1:0])
        2'd0:    esc_byte = ttp_pkg::CH_BSLASH;
        2'd1:    esc_byte = ttp_pkg::CH_ZERO | {6'd0, ch_q[7:6]};
        2'd2:    esc_byte = ttp_pkg::CH_ZERO | {5'd0, ch_q[5:3]};
        default: esc_byte = ttp_pkg::CH_ZERO | {5'd0, ch_q[2:0]};
      endcase
    end else if (is_esc) begin
      esc_last = (idx_q == ttp_pkg::IdxW'(1));
      esc_byte = (idx_q == '0) ? ttp_pkg::CH_BSLASH : ch_q;
    end else begin
      esc_last = (idx_q == '0);
    end
  end

  // Select the byte and the end of the current segment
  always_comb begin
    unique case (cmd_i.seg)
      ttp_pkg::SEG_ESC: begin
        byte_sel = esc_byte;
        seg_last = esc_last;
      end
      ttp_pkg::SEG_TAB: begin
        byte_sel = ttp_pkg::CH_SPACE;
        seg_last = ({1'b0, idx_q} == (n_spaces - 1'b1));
      end
      default: begin
        byte_sel = ttp_pkg::str_byte(cmd_i.seg, idx_q[2:0]);
        seg_last = (idx_q == {{(ttp_pkg::IdxW-3){1'b0}}, ttp_pkg::str_last(cmd_i.seg)});
      end
    endcase
  end

  // Counters and segment position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      line_q   <= ttp_pkg::LINE_ONE;
      idx_q    <= '0;
    end else begin
      if (cmd_i.emit) begin
        idx_q <= cmd_i.seg_end ? '0 : idx_q + 1'b1;
      end
      if (cmd_i.col_clear) begin
        column_q <= '0;
      end else if (cmd_i.col_inc) begin
        if (column_q != '1) begin
          column_q <= column_q + 1'b1;
        end
      end else if (cmd_i.col_tab) begin
        column_q <= tab_stop[ttp_pkg::ColW] ? '1 : tab_stop[ttp_pkg::ColW-1:0];
      end
      if (cmd_i.line_reset) begin
        line_q <= ttp_pkg::LINE_ONE;
      end else if (cmd_i.line_adv) begin
        line_q <= page ? ttp_pkg::LINE_ONE : line_next[ttp_pkg::LineW-1:0];
      end
    end
  end

  // Hold the character of the accepted request
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ch_q <= map_ch;
    end
  end

  // Output register: load on emit, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_byte_q <= byte_sel;
      out_last_q <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  assign sts_o.kind     = kind;
  assign sts_o.wrap     = column_q >= cfg_i.line_width_limit;
  assign sts_o.page     = page;
  assign sts_o.seg_last = seg_last;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.div_busy = div_busy;

endmodule

>>> src/ttp_ctrl.sv
// ----------------------------------------------------------------------------
// ttp_ctrl
// Sequencer: walks the output segments of one request and issues counter updates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ttp_pkg::sts_t  sts_i,
  output ttp_pkg::cmd_t  cmd_o
);

  ttp_pkg::seg_e state_q, state_d;
  logic          pend_q, pend_d;

  // State register and pending-character flag for a wrapped byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ttp_pkg::SEG_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    pend_d     = pend_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.seg  = state_q;

    unique case (state_q)
      ttp_pkg::SEG_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          unique case (sts_i.kind)
            ttp_pkg::KIND_OPEN: state_d = ttp_pkg::SEG_OPEN;
            ttp_pkg::KIND_EOF:  state_d = ttp_pkg::SEG_EOF;
            ttp_pkg::KIND_TAB: begin
              cmd_o.div_start = 1'b1;
              state_d         = ttp_pkg::SEG_DIV;
            end
            ttp_pkg::KIND_NL: begin
              pend_d  = 1'b0;
              state_d = ttp_pkg::SEG_NLHEAD;
            end
            ttp_pkg::KIND_CR:   state_d = ttp_pkg::SEG_CR;
            ttp_pkg::KIND_FF:   state_d = ttp_pkg::SEG_FF;
            ttp_pkg::KIND_CHAR: begin
              pend_d  = sts_i.wrap;
              state_d = sts_i.wrap ? ttp_pkg::SEG_NLHEAD : ttp_pkg::SEG_ESC;
            end
            default: state_d = ttp_pkg::SEG_IDLE;
          endcase
        end
      end

      ttp_pkg::SEG_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = ttp_pkg::SEG_TAB;
        end
      end

      default: begin
        if (sts_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.seg_end = sts_i.seg_last;
          case (state_q) inside
            ttp_pkg::SEG_NLHEAD, ttp_pkg::SEG_PAGE: cmd_o.last = 1'b0;
            ttp_pkg::SEG_NLOPEN: cmd_o.last = sts_i.seg_last && !pend_q;
            default:             cmd_o.last = sts_i.seg_last;
          endcase
          if (sts_i.seg_last) begin
            case (state_q)
              ttp_pkg::SEG_OPEN: begin
                cmd_o.col_clear  = 1'b1;
                cmd_o.line_reset = 1'b1;
                state_d          = ttp_pkg::SEG_IDLE;
              end
              ttp_pkg::SEG_NLHEAD: begin
                cmd_o.col_clear = 1'b1;
                cmd_o.line_adv  = 1'b1;
                state_d = sts_i.page ? ttp_pkg::SEG_PAGE : ttp_pkg::SEG_NLOPEN;
              end
              ttp_pkg::SEG_PAGE: state_d = ttp_pkg::SEG_NLOPEN;
              ttp_pkg::SEG_NLOPEN: begin
                state_d = pend_q ? ttp_pkg::SEG_ESC : ttp_pkg::SEG_IDLE;
              end
              ttp_pkg::SEG_CR: begin
                cmd_o.col_clear = 1'b1;
                state_d         = ttp_pkg::SEG_IDLE;
              end
              ttp_pkg::SEG_FF: begin
                cmd_o.col_clear  = 1'b1;
                cmd_o.line_reset = 1'b1;
                state_d          = ttp_pkg::SEG_IDLE;
              end
              ttp_pkg::SEG_ESC: begin
                cmd_o.col_inc = 1'b1;
                state_d       = ttp_pkg::SEG_IDLE;
              end
              ttp_pkg::SEG_TAB: begin
                cmd_o.col_tab = 1'b1;
                state_d       = ttp_pkg::SEG_IDLE;
              end
              default: state_d = ttp_pkg::SEG_IDLE;
            endcase
          end
        end
      end
    endcase
  end

endmodule

>>> src/ttp_checker.sv
// ----------------------------------------------------------------------------
// ttp_checker
// Port-level properties of the encoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_to_page_command_encoder_core_macros.svh"

module ttp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic [ttp_pkg::OpW-1:0]     in_opcode_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [ttp_pkg::ByteW-1:0]   out_byte_i,
  input logic                        out_last_i,
  input logic                        psel_i,
  input logic                        penable_i,
  input logic                        pwrite_i,
  input logic [ttp_pkg::AddrW-1:0]   paddr_i,
  input logic [ttp_pkg::DataW-1:0]   pwdata_i,
  input logic [ttp_pkg::DataW-1:0]   prdata_i
);

  logic in_acc;
  logic cfg_wr;

  assign in_acc = in_valid_i && in_ready_i;
  assign cfg_wr = psel_i && penable_i && pwrite_i;

  // A stalled result holds its value
  `TTP_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
    out_valid_i && $stable(out_byte_i) && $stable(out_last_i))

  // A data request always produces bytes, so the input closes behind it
  `TTP_ASSERT_NEXT(a_data_busy, in_acc && (in_opcode_i == ttp_pkg::OP_DATA), !in_ready_i)

  // An unused opcode is dropped and the input stays open
  `TTP_ASSERT_NEXT(a_none_drop, in_acc && (in_opcode_i == ttp_pkg::OP_NONE), in_ready_i)

  // A tab width write reads back on the next cycle
  `TTP_ASSERT_NOW(a_tab_readback,
    (cfg_wr && (paddr_i[3:2] == ttp_pkg::REG_TAB_WIDTH)) ##1
    (paddr_i[3:2] == ttp_pkg::REG_TAB_WIDTH),
    prdata_i[ttp_pkg::TabW-1:0] == $past(pwdata_i[ttp_pkg::TabW-1:0]))

endmodule

bind text_to_page_command_encoder_core ttp_checker u_ttp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_chan.valid),
  .in_ready_i  (in_chan.ready),
  .in_opcode_i (in_chan.opcode),
  .out_valid_i (out_chan.valid),
  .out_ready_i (out_chan.ready),
  .out_byte_i  (out_chan.out_byte),
  .out_last_i  (out_chan.last_of_run),
  .psel_i      (psel),
  .penable_i   (penable),
  .pwrite_i    (pwrite),
  .paddr_i     (paddr),
  .pwdata_i    (pwdata),
  .prdata_i    (prdata)
);

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text to page-command encoder. A short table of
// directed requests covers the byte classes, escapes and open cases, then
// random files under several register settings, a long output hold-off and
// a back-to-back tab run that ends in a wrap with a page break. Every command
// byte is compared against the in-bench encoder model or a typed table row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int         SETTLE_CYCLES = 64;
  localparam int         HOLD_CYCLES   = 400;
  localparam int         QUIET_LIMIT   = 4000;
  localparam int         ITEMS_PER_SET = 38;
  localparam int         NPLAN         = 7;
  localparam int         PRESS_SET     = 4;
  localparam int         NDIR          = 25;
  localparam int         RUN_MAX       = 32;
  localparam int         COL_TOP       = 65535;
  localparam int         TAB_RUN       = 20;
  localparam int         RUN_LINE      = 40;
  localparam int         RUN_PAGE      = 1;
  localparam logic [3:0] BY_MODEL      = 4'hF;

  typedef struct packed {
    logic [ttp_pkg::ByteW-1:0] data;
    logic                      last;
  } cmd_byte_t;

  // One directed request; want holds the typed command bytes, first byte leftmost
  typedef struct packed {
    logic [ttp_pkg::OpW-1:0]   op;
    logic [ttp_pkg::ByteW-1:0] ch;
    logic [3:0]                want_n;
    logic [55:0]               want;
  } dir_row_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [ttp_pkg::AddrW-1:0]   paddr;
  logic [ttp_pkg::DataW-1:0]   pwdata;
  logic [ttp_pkg::DataW-1:0]   prdata;
  logic                        pready;

  ttp_in_if  in_if ();
  ttp_out_if out_if ();

  text_to_page_command_encoder_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Encoder model state and register copy
  logic [ttp_pkg::TabW-1:0]  tab_w    = ttp_pkg::TAB_WIDTH_RST;
  logic [ttp_pkg::ColW-1:0]  line_lim = ttp_pkg::LINE_WIDTH_RST;
  logic [ttp_pkg::LineW-1:0] page_lim = ttp_pkg::PAGE_LINES_RST;
  logic [ttp_pkg::ColW-1:0]  col      = '0;
  logic [ttp_pkg::LineW-1:0] line_no  = ttp_pkg::LINE_ONE;

  logic [ttp_pkg::ByteW-1:0] run_q[$];
  cmd_byte_t                 cmd_due_q[$];
  cmd_byte_t                 due_byte;

  bit src_idle = 1'b1;
  bit snk_idle = 1'b1;
  bit hold_req = 1'b0;
  int err_cnt  = 0;
  int req_cnt  = 0;
  int byte_cnt = 0;
  int hold_cnt = 0;
  int quiet_cycles = 0;

  int unsigned plan_tab  [NPLAN] = '{0, 63, 1, 32, 7, 17, 5};
  int unsigned plan_line [NPLAN] = '{0, 65535, 1, 5, 12, 30, 3};
  int unsigned plan_page [NPLAN] = '{0, 65535, 1, 3, 4, 2, 1};

  dir_row_t dir_tbl [NDIR] = '{
    '{ttp_pkg::OP_START, 8'h00,              4'd1,     "("},
    '{ttp_pkg::OP_DATA,  "A",                4'd1,     "A"},
    '{ttp_pkg::OP_DATA,  ttp_pkg::CH_LPAREN, 4'd2,     "\\("},
    '{ttp_pkg::OP_DATA,  ttp_pkg::CH_RPAREN, 4'd2,     "\\)"},
    '{ttp_pkg::OP_DATA,  ttp_pkg::CH_BSLASH, 4'd2,     "\\\\"},
    '{ttp_pkg::OP_DATA,  ttp_pkg::CH_SPACE,  4'd1,     " "},
    '{ttp_pkg::OP_DATA,  ttp_pkg::CH_TILDE,  4'd1,     "~"},
    '{ttp_pkg::OP_DATA,  8'h7F,              4'd4,     "\\177"},
    '{ttp_pkg::OP_DATA,  8'h80,              4'd4,     "\\200"},
    '{ttp_pkg::OP_DATA,  8'hFF,              4'd4,     "\\377"},
    '{ttp_pkg::OP_DATA,  8'h00,              4'd1,     "?"},
    '{ttp_pkg::OP_DATA,  8'h1F,              4'd1,     "?"},
    '{ttp_pkg::OP_DATA,  8'h08,              4'd1,     "?"},
    '{ttp_pkg::OP_DATA,  ttp_pkg::CH_QMARK,  4'd1,     "?"},
    '{ttp_pkg::OP_DATA,  ttp_pkg::CH_TAB,    BY_MODEL, 56'h0},
    '{ttp_pkg::OP_DATA,  ttp_pkg::CH_NL,     4'd5,     ") n\n("},
    '{ttp_pkg::OP_DATA,  ttp_pkg::CH_TAB,    BY_MODEL, 56'h0},
    '{ttp_pkg::OP_DATA,  "b",                BY_MODEL, 56'h0},
    '{ttp_pkg::OP_DATA,  ttp_pkg::CH_CR,     4'd5,     ") r\n("},
    '{ttp_pkg::OP_DATA,  ttp_pkg::CH_FF,     4'd7,     ") n p\n("},
    '{ttp_pkg::OP_NONE,  8'h55,              4'd0,     56'h0},
    '{ttp_pkg::OP_NONE,  8'hAA,              4'd0,     56'h0},
    '{ttp_pkg::OP_END,   8'h00,              4'd7,     ") n p\n\014"},
    '{ttp_pkg::OP_DATA,  "z",                BY_MODEL, 56'h0},
    '{ttp_pkg::OP_END,   8'hFF,              4'd7,     ") n p\n\014"}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Encoder model
  // --------------------------------------------------------------------------
  function automatic void put_byte(logic [ttp_pkg::ByteW-1:0] b);
    if (run_q.size() < RUN_MAX) run_q.push_back(b);
  endfunction

  // Close the line, add a page break once past the page limit, reopen
  function automatic void line_break();
    logic [ttp_pkg::LineW:0] nxt;
    nxt = {1'b0, line_no} + 1'b1;
    put_byte(ttp_pkg::CH_RPAREN);
    put_byte(ttp_pkg::CH_SPACE);
    put_byte(ttp_pkg::CH_LOW_N);
    put_byte(ttp_pkg::CH_NL);
    if (nxt > {1'b0, page_lim}) begin
      put_byte(ttp_pkg::CH_LOW_P);
      put_byte(ttp_pkg::CH_NL);
      line_no = ttp_pkg::LINE_ONE;
    end else begin
      line_no = nxt[ttp_pkg::LineW-1:0];
    end
    col = '0;
    put_byte(ttp_pkg::CH_LPAREN);
  endfunction

  function automatic void encode_request(logic [ttp_pkg::OpW-1:0] op,
                                         logic [ttp_pkg::ByteW-1:0] ch_in);
    logic [ttp_pkg::ByteW-1:0] ch;
    int                        t;
    int                        stop;
    int                        i;
    run_q.delete();
    ch = ch_in;
    case (op)
      ttp_pkg::OP_START: begin
        col = '0;
        line_no = ttp_pkg::LINE_ONE;
        put_byte(ttp_pkg::CH_LPAREN);
      end
      ttp_pkg::OP_END: begin
        put_byte(ttp_pkg::CH_RPAREN);
        put_byte(ttp_pkg::CH_SPACE);
        put_byte(ttp_pkg::CH_LOW_N);
        put_byte(ttp_pkg::CH_SPACE);
        put_byte(ttp_pkg::CH_LOW_P);
        put_byte(ttp_pkg::CH_NL);
        put_byte(ttp_pkg::CH_FF);
      end
      ttp_pkg::OP_DATA: begin
        // Map stray control bytes to a question mark
        if (ch < ttp_pkg::CH_SPACE && ch != ttp_pkg::CH_TAB && ch != ttp_pkg::CH_NL &&
            ch != ttp_pkg::CH_CR && ch != ttp_pkg::CH_FF)
          ch = ttp_pkg::CH_QMARK;
        if (ch == ttp_pkg::CH_TAB) begin
          t = (tab_w == 0) ? 1 : (tab_w > ttp_pkg::MAX_TAB) ? ttp_pkg::MAX_TAB : int'(tab_w);
          stop = int'(col) + t - (int'(col) % t);
          for (i = int'(col); i < stop; i++) put_byte(ttp_pkg::CH_SPACE);
          col = (stop > COL_TOP) ? ttp_pkg::ColW'(COL_TOP) : ttp_pkg::ColW'(stop);
        end else if (ch == ttp_pkg::CH_NL) begin
          line_break();
        end else if (ch == ttp_pkg::CH_CR) begin
          put_byte(ttp_pkg::CH_RPAREN);
          put_byte(ttp_pkg::CH_SPACE);
          put_byte(ttp_pkg::CH_LOW_R);
          put_byte(ttp_pkg::CH_NL);
          put_byte(ttp_pkg::CH_LPAREN);
          col = '0;
        end else if (ch == ttp_pkg::CH_FF) begin
          put_byte(ttp_pkg::CH_RPAREN);
          put_byte(ttp_pkg::CH_SPACE);
          put_byte(ttp_pkg::CH_LOW_N);
          put_byte(ttp_pkg::CH_SPACE);
          put_byte(ttp_pkg::CH_LOW_P);
          put_byte(ttp_pkg::CH_NL);
          put_byte(ttp_pkg::CH_LPAREN);
          line_no = ttp_pkg::LINE_ONE;
          col = '0;
        end else begin
          if (col >= line_lim) line_break();
          if (ch > ttp_pkg::CH_TILDE) begin
            put_byte(ttp_pkg::CH_BSLASH);
            put_byte(ttp_pkg::CH_ZERO + ttp_pkg::ByteW'(ch[7:6]));
            put_byte(ttp_pkg::CH_ZERO + ttp_pkg::ByteW'(ch[5:3]));
            put_byte(ttp_pkg::CH_ZERO + ttp_pkg::ByteW'(ch[2:0]));
          end else begin
            if (ch == ttp_pkg::CH_LPAREN || ch == ttp_pkg::CH_RPAREN ||
                ch == ttp_pkg::CH_BSLASH)
              put_byte(ttp_pkg::CH_BSLASH);
            put_byte(ch);
          end
          if (col != ttp_pkg::ColW'(COL_TOP)) col = col + 1'b1;
        end
      end
      default: begin
        // unused opcode: drop
      end
    endcase
  endfunction

  function automatic logic [ttp_pkg::DataW-1:0] reg_copy(logic [1:0] idx);
    logic [ttp_pkg::DataW-1:0] v;
    case (idx)
      ttp_pkg::REG_TAB_WIDTH:  v = ttp_pkg::DataW'(tab_w);
      ttp_pkg::REG_LINE_WIDTH: v = ttp_pkg::DataW'(line_lim);
      ttp_pkg::REG_PAGE_LINES: v = ttp_pkg::DataW'(page_lim);
      default:                 v = '0;
    endcase
    return v;
  endfunction

  // Text-like byte mix: printable bytes most often, with specials, escapes and noise
  function automatic void pick_text(output logic [ttp_pkg::OpW-1:0] op,
                                    output logic [ttp_pkg::ByteW-1:0] ch);
    int unsigned r;
    r = $urandom_range(0, 99);
    op = ttp_pkg::OP_DATA;
    ch = ttp_pkg::ByteW'($urandom);
    if (r < 40) ch = ttp_pkg::ByteW'($urandom_range(8'h21, 8'h7E));
    else if (r < 48) ch = ttp_pkg::CH_TAB;
    else if (r < 56) ch = ttp_pkg::CH_NL;
    else if (r < 60) ch = ttp_pkg::CH_CR;
    else if (r < 63) ch = ttp_pkg::CH_FF;
    else if (r < 66) ch = ttp_pkg::CH_LPAREN;
    else if (r < 68) ch = ttp_pkg::CH_RPAREN;
    else if (r < 70) ch = ttp_pkg::CH_BSLASH;
    else if (r < 80) ch = ttp_pkg::ByteW'($urandom_range(8'h7F, 8'hFF));
    else if (r < 86) ch = ttp_pkg::ByteW'($urandom_range(0, 31));
    else if (r < 92) op = ttp_pkg::OP_NONE;
    else if (r < 96) op = ttp_pkg::OP_START;
    else op = ttp_pkg::OP_END;
  endfunction

  // --------------------------------------------------------------------------
  // Input request driver
  // --------------------------------------------------------------------------
  task automatic send_request(logic [ttp_pkg::OpW-1:0] op, logic [ttp_pkg::ByteW-1:0] ch,
                              logic [3:0] want_n, logic [55:0] want);
    int i;
    int n;
    if (src_idle && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.opcode  <= op;
    in_if.in_byte <= ch;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    // Predict on acceptance; typed rows override the model bytes
    encode_request(op, ch);
    if (want_n != BY_MODEL) begin
      run_q.delete();
      for (i = 0; i < want_n; i++) run_q.push_back(want[(want_n - 1 - i) * 8 +: 8]);
    end
    n = run_q.size();
    for (i = 0; i < n; i++) cmd_due_q.push_back('{data: run_q[i], last: (i == n - 1)});
    req_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // Register access
  // --------------------------------------------------------------------------
  task automatic apb_xfer(bit wr, logic [1:0] idx, logic [ttp_pkg::DataW-1:0] wdata,
                          output logic [ttp_pkg::DataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_reg(logic [1:0] idx);
    logic [ttp_pkg::DataW-1:0] rd;
    apb_xfer(1'b0, idx, '0, rd);
    if (rd !== reg_copy(idx)) begin
      $display("%0t: register %0d readback: expected %h, got %h", $time, idx, reg_copy(idx), rd);
      err_cnt++;
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [ttp_pkg::DataW-1:0] val);
    logic [ttp_pkg::DataW-1:0] rd;
    apb_xfer(1'b1, idx, val, rd);
    case (idx)
      ttp_pkg::REG_TAB_WIDTH:  tab_w    = val[ttp_pkg::TabW-1:0];
      ttp_pkg::REG_LINE_WIDTH: line_lim = val[ttp_pkg::ColW-1:0];
      ttp_pkg::REG_PAGE_LINES: page_lim = val[ttp_pkg::LineW-1:0];
      default: ;
    endcase
    check_reg(idx);
  endtask

  // Drain all pending bytes, let a dropped request settle, then reprogram
  task automatic apply_settings(int unsigned t, int unsigned l, int unsigned pg);
    in_if.valid <= 1'b0;
    while (cmd_due_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(ttp_pkg::REG_TAB_WIDTH, ttp_pkg::DataW'(t));
    write_reg(ttp_pkg::REG_LINE_WIDTH, ttp_pkg::DataW'(l));
    write_reg(ttp_pkg::REG_PAGE_LINES, ttp_pkg::DataW'(pg));
  endtask

  // --------------------------------------------------------------------------
  // Output side: ready bursts, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        hold_cnt++;
      end else if (snk_idle && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // Compare each accepted command byte with the oldest pending one
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (cmd_due_q.size() == 0) begin
        $display("%0t: unexpected byte: expected none, got %h last %b",
                 $time, out_if.out_byte, out_if.last_of_run);
        err_cnt++;
      end else begin
        due_byte = cmd_due_q.pop_front();
        byte_cnt++;
        if (out_if.out_byte !== due_byte.data) begin
          $display("%0t: out_byte mismatch: expected %h, got %h",
                   $time, due_byte.data, out_if.out_byte);
          err_cnt++;
        end
        if (out_if.last_of_run !== due_byte.last) begin
          $display("%0t: last_of_run mismatch: expected %b, got %b",
                   $time, due_byte.last, out_if.last_of_run);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: abort when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [ttp_pkg::OpW-1:0]   op;
    logic [ttp_pkg::ByteW-1:0] ch;
    int                        k;
    int                        p;
    int                        n;
    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.opcode  <= ttp_pkg::OP_DATA;
    in_if.in_byte <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values of the registers
    check_reg(ttp_pkg::REG_TAB_WIDTH);
    check_reg(ttp_pkg::REG_LINE_WIDTH);
    check_reg(ttp_pkg::REG_PAGE_LINES);

    // Directed table under reset settings
    for (k = 0; k < NDIR; k++)
      send_request(dir_tbl[k].op, dir_tbl[k].ch, dir_tbl[k].want_n, dir_tbl[k].want);

    // Random files under planned settings, then one random setting
    for (p = 0; p <= NPLAN; p++) begin
      if (p < NPLAN)
        apply_settings(plan_tab[p], plan_line[p], plan_page[p]);
      else
        apply_settings($urandom_range(0, 63), $urandom_range(0, 24), $urandom_range(0, 6));
      src_idle = ($urandom_range(0, 3) != 0);
      snk_idle = ($urandom_range(0, 3) != 0);
      // Stall the output long enough for the input to back up
      if (p == PRESS_SET) hold_req = 1'b1;
      send_request(ttp_pkg::OP_START, ttp_pkg::ByteW'($urandom), BY_MODEL, '0);
      n = 0;
      while (n < ITEMS_PER_SET) begin
        if ($urandom_range(0, 29) == 0) begin
          send_request(ttp_pkg::OP_END, ttp_pkg::ByteW'($urandom), BY_MODEL, '0);
          send_request(ttp_pkg::OP_START, ttp_pkg::ByteW'($urandom), BY_MODEL, '0);
        end
        pick_text(op, ch);
        send_request(op, ch, BY_MODEL, '0);
        if (op != ttp_pkg::OP_NONE) n++;
      end
      send_request(ttp_pkg::OP_END, ttp_pkg::ByteW'($urandom), BY_MODEL, '0);
    end

    // Back-to-back tab run at the widest stop, then a wrap with a page break
    apply_settings(ttp_pkg::MAX_TAB, RUN_LINE, RUN_PAGE);
    src_idle = 1'b0;
    snk_idle = 1'b0;
    send_request(ttp_pkg::OP_START, '0, BY_MODEL, '0);
    repeat (TAB_RUN) send_request(ttp_pkg::OP_DATA, ttp_pkg::CH_TAB, BY_MODEL, '0);
    send_request(ttp_pkg::OP_DATA, "x", BY_MODEL, '0);
    send_request(ttp_pkg::OP_END, '0, BY_MODEL, '0);

    in_if.valid <= 1'b0;
    while (cmd_due_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d requests and %0d command bytes over %0d register settings,",
             req_cnt, byte_cnt, NPLAN + 3);
    $display("with %0d long output hold-off(s) and a back-to-back tab run ending in a wrap.",
             hold_cnt);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/ttp_pkg.sv
src/ttp_in_if.sv
src/ttp_out_if.sv
src/ttp_regs.sv
src/ttp_rem.sv
src/ttp_datapath.sv
src/ttp_ctrl.sv
src/text_to_page_command_encoder_core.sv
src/ttp_checker.sv
bench/tb_top.sv
